// ===== rtl/gcm_pkg.sv =====
package gcm_pkg;

   // default width of the amount in cents
   localparam int AMOUNT_BITS_DEFAULT = 20;

   // denomination table, largest first
   localparam int DENOM_COUNT = 10;
   localparam int unsigned DENOM_TABLE [DENOM_COUNT] = '{
      10000, 5000, 2000, 1000, 500, 100, 25, 10, 5, 1
   };

   // result field widths
   localparam int VALUE_BITS = 14;
   localparam int COUNT_BITS = 7;

   // width of what is left once hundred-dollar pieces are taken out
   localparam int REM_BITS = 14;

   // hundred-dollar split: count, nonzero flag and remainder below 10000
   typedef struct packed {
      logic [COUNT_BITS-1:0] top_count;
      logic                  top_nonzero;
      logic [REM_BITS-1:0]   rest;
   } hund_split_type;

   // full breakdown of one amount
   typedef struct packed {
      logic [DENOM_COUNT-1:0][COUNT_BITS-1:0] counts;
      logic [DENOM_COUNT-1:0]                 present;
   } piece_set_type;

endpackage

// ===== rtl/gcm_if.sv =====
// amount channel
interface gcm_req_if
   import gcm_pkg::*;
#(
   parameter int AMOUNT_BITS = AMOUNT_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [AMOUNT_BITS-1:0] amount_cents;

   modport source (output valid, output amount_cents, input ready);
   modport sink (input valid, input amount_cents, output ready);
endinterface

// piece channel
interface gcm_rsp_if
   import gcm_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] piece_value;
   logic [COUNT_BITS-1:0] piece_count;
   logic                  last_piece;

   modport source (output valid, output piece_value, output piece_count, output last_piece,
                   input ready);
   modport sink (input valid, input piece_value, input piece_count, input last_piece,
                 output ready);
endinterface

// ===== rtl/gcm_divider.sv =====
module gcm_divider
   import gcm_pkg::*;
#(
   parameter int AMOUNT_BITS = AMOUNT_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   gcm_req_if.sink        req_chan,
   output logic           split_valid,
   input  logic           split_ready,
   output hund_split_type split_word
);

   localparam int PROD_BITS = 2 * AMOUNT_BITS;
   localparam int WIDE_BITS = (AMOUNT_BITS > REM_BITS + 1) ? AMOUNT_BITS : REM_BITS + 1;
   // reciprocal of the top denomination, scaled by 2^AMOUNT_BITS, rounded down
   localparam logic [AMOUNT_BITS-1:0] RECIP =
      AMOUNT_BITS'((64'd1 << AMOUNT_BITS) / 64'(DENOM_TABLE[0]));

   logic                   a_valid_ff, a_valid_in;
   logic [AMOUNT_BITS-1:0] a_amount_ff, a_amount_in;
   logic                   b_valid_ff, b_valid_in;
   logic [AMOUNT_BITS-1:0] b_amount_ff, b_amount_in;
   logic [AMOUNT_BITS-1:0] b_quot_ff, b_quot_in;
   logic                   a_ready, b_ready;
   logic [PROD_BITS-1:0]   recip_prod;
   logic [AMOUNT_BITS-1:0] rem_est;
   logic [AMOUNT_BITS-1:0] quot_full;
   logic [WIDE_BITS-1:0]   rem_wide;
   logic                   fix;

   // stage handshake
   assign b_ready        = !b_valid_ff || split_ready;
   assign a_ready        = !a_valid_ff || b_ready;
   assign req_chan.ready = a_ready;

   // input register
   always_comb begin
      a_valid_in  = a_valid_ff;
      a_amount_in = a_amount_ff;
      if (a_ready) begin
         a_valid_in  = req_chan.valid;
         a_amount_in = req_chan.amount_cents;
      end
   end

   // quotient estimate, low by at most one
   assign recip_prod = PROD_BITS'(a_amount_ff) * PROD_BITS'(RECIP);

   always_comb begin
      b_valid_in  = b_valid_ff;
      b_amount_in = b_amount_ff;
      b_quot_in   = b_quot_ff;
      if (b_ready) begin
         b_valid_in  = a_valid_ff;
         b_amount_in = a_amount_ff;
         b_quot_in   = AMOUNT_BITS'(recip_prod >> AMOUNT_BITS);
      end
   end

   // remainder and one correction step
   always_comb begin
      rem_est   = b_amount_ff - AMOUNT_BITS'(b_quot_ff * AMOUNT_BITS'(DENOM_TABLE[0]));
      rem_wide  = WIDE_BITS'(rem_est);
      fix       = rem_wide >= WIDE_BITS'(DENOM_TABLE[0]);
      quot_full = b_quot_ff + AMOUNT_BITS'(fix);
      split_word.top_count   = quot_full[COUNT_BITS-1:0];
      split_word.top_nonzero = quot_full != '0;
      split_word.rest        = fix ? REM_BITS'(rem_wide - WIDE_BITS'(DENOM_TABLE[0]))
                                   : REM_BITS'(rem_wide);
   end

   assign split_valid = b_valid_ff;

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_amount_ff <= a_amount_in;
      b_amount_ff <= b_amount_in;
      b_quot_ff   <= b_quot_in;
   end

endmodule

// ===== rtl/gcm_splitter.sv =====
module gcm_splitter
   import gcm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           split_valid,
   output logic           split_ready,
   input  hund_split_type split_word,
   output logic           set_valid,
   input  logic           set_ready,
   output piece_set_type  set_word
);

   // first denomination handled by the fine stage
   localparam int FINE_FIRST = 5;
   // no denomination below the top one is taken more than four times
   localparam int SMALL_COUNT_MAX = 4;

   logic                  c_valid_ff, c_valid_in;
   piece_set_type         c_set_ff, c_set_in;
   logic [REM_BITS-1:0]   c_rem_ff, c_rem_in;
   logic                  d_valid_ff, d_valid_in;
   piece_set_type         d_set_ff, d_set_in;
   logic                  c_ready, d_ready;
   piece_set_type         coarse_set, fine_set;
   logic [REM_BITS-1:0]   coarse_rem, fine_rem;
   logic [COUNT_BITS-1:0] coarse_cnt, fine_cnt;

   // pieces of one denomination that fit in what is left
   function automatic logic [COUNT_BITS-1:0] piece_take(input logic [REM_BITS-1:0] rem,
                                                        input int unsigned denom);
      logic [COUNT_BITS-1:0] count;
      count = '0;
      for (int i = 1; i <= SMALL_COUNT_MAX; i++) begin
         if (32'(rem) >= 32'(i) * denom) count = COUNT_BITS'(i);
      end
      return count;
   endfunction

   // stage handshake
   assign d_ready     = !d_valid_ff || set_ready;
   assign c_ready     = !c_valid_ff || d_ready;
   assign split_ready = c_ready;

   // coarse split: hundred-dollar count from the divider, then bills from fifty down to five dollars
   always_comb begin
      coarse_set            = '0;
      coarse_set.counts[0]  = split_word.top_count;
      coarse_set.present[0] = split_word.top_nonzero;
      coarse_rem            = split_word.rest;
      coarse_cnt            = '0;
      for (int i = 1; i < FINE_FIRST; i++) begin
         coarse_cnt            = piece_take(coarse_rem, DENOM_TABLE[i]);
         coarse_set.counts[i]  = coarse_cnt;
         coarse_set.present[i] = coarse_cnt != '0;
         coarse_rem            = coarse_rem - REM_BITS'(32'(coarse_cnt) * DENOM_TABLE[i]);
      end
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      c_set_in   = c_set_ff;
      c_rem_in   = c_rem_ff;
      if (c_ready) begin
         c_valid_in = split_valid;
         c_set_in   = coarse_set;
         c_rem_in   = coarse_rem;
      end
   end

   // fine split: dollar bill and coins
   always_comb begin
      fine_set = c_set_ff;
      fine_rem = c_rem_ff;
      fine_cnt = '0;
      for (int i = FINE_FIRST; i < DENOM_COUNT; i++) begin
         fine_cnt            = piece_take(fine_rem, DENOM_TABLE[i]);
         fine_set.counts[i]  = fine_cnt;
         fine_set.present[i] = fine_cnt != '0;
         fine_rem            = fine_rem - REM_BITS'(32'(fine_cnt) * DENOM_TABLE[i]);
      end
   end

   always_comb begin
      d_valid_in = d_valid_ff;
      d_set_in   = d_set_ff;
      if (d_ready) begin
         d_valid_in = c_valid_ff;
         d_set_in   = fine_set;
      end
   end

   assign set_valid = d_valid_ff;
   assign set_word  = d_set_ff;

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
      c_set_ff <= c_set_in;
      c_rem_ff <= c_rem_in;
      d_set_ff <= d_set_in;
   end

endmodule

// ===== rtl/gcm_emitter.sv =====
module gcm_emitter
   import gcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          set_valid,
   output logic          set_ready,
   input  piece_set_type set_word,
   gcm_rsp_if.source     rsp_chan
);

   logic [DENOM_COUNT-1:0]                 pend_ff, pend_in;
   logic [DENOM_COUNT-1:0][COUNT_BITS-1:0] counts_ff, counts_in;
   logic [DENOM_COUNT-1:0]                 sel_hot;
   logic [VALUE_BITS-1:0]                  sel_value;
   logic [COUNT_BITS-1:0]                  sel_count;
   logic                                   sel_last;
   logic                                   fire;

   // largest pending denomination goes out first
   always_comb begin
      sel_hot   = '0;
      sel_value = '0;
      sel_count = '0;
      for (int i = DENOM_COUNT - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel_hot    = '0;
            sel_hot[i] = 1'b1;
            sel_value  = VALUE_BITS'(DENOM_TABLE[i]);
            sel_count  = counts_ff[i];
         end
      end
      sel_last = (pend_ff & ~sel_hot) == '0;
   end

   // word out
   assign rsp_chan.valid       = |pend_ff;
   assign rsp_chan.piece_value = sel_value;
   assign rsp_chan.piece_count = sel_count;
   assign rsp_chan.last_piece  = sel_last;

   assign fire      = rsp_chan.valid && rsp_chan.ready;
   assign set_ready = !rsp_chan.valid || (fire && sel_last);

   // load a new breakdown or retire the word just taken
   always_comb begin
      pend_in   = pend_ff;
      counts_in = counts_ff;
      if (set_valid && set_ready) begin
         pend_in   = set_word.present;
         counts_in = set_word.counts;
      end else if (fire) begin
         pend_in = pend_ff & ~sel_hot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
      counts_ff <= counts_in;
   end

endmodule

// ===== rtl/greedy_change_maker_top.sv =====
// Greedy change maker, US denominations.
// req_chan carries one amount in cents per word (valid/ready, taken when both
// are high). rsp_chan returns one word per nonzero denomination, largest
// value first, with the piece value, the piece count and last_piece set on
// the final word of the amount. A zero amount returns nothing.
// The first word of an amount passes the input register, the reciprocal
// multiply, the correction and coarse split, the fine split, then the
// emitter register.
// Throughput: the emitter sends one word per cycle while rsp_chan.ready is
// high, and a nonzero amount gives 1 to 10 words; a new breakdown loads in
// the cycle its predecessor's last word is taken. The four pipeline stages
// hold further amounts, and req_chan.ready stays high while any of them is
// free, so amounts are taken every cycle as long as the emitter keeps pace.
// Reset clears every stage valid and the emitter's pending mask; no word is
// shown in the cycle after reset.
// When the receiver holds rsp_chan.ready low the current word holds steady,
// the pipeline fills and then drops req_chan.ready; nothing is lost.
module greedy_change_maker_top
   import gcm_pkg::*;
#(
   parameter int AMOUNT_BITS = AMOUNT_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   gcm_req_if.sink   req_chan,
   gcm_rsp_if.source rsp_chan
);

   logic           split_valid, split_ready;
   hund_split_type split_word;
   logic           set_valid, set_ready;
   piece_set_type  set_word;

   // hundred-dollar division
   gcm_divider #(
      .AMOUNT_BITS(AMOUNT_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .split_valid(split_valid),
      .split_ready(split_ready),
      .split_word (split_word)
   );

   // smaller denominations
   gcm_splitter u_splitter (
      .clock      (clock),
      .reset      (reset),
      .split_valid(split_valid),
      .split_ready(split_ready),
      .split_word (split_word),
      .set_valid  (set_valid),
      .set_ready  (set_ready),
      .set_word   (set_word)
   );

   // one word per nonzero denomination
   gcm_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .set_valid(set_valid),
      .set_ready(set_ready),
      .set_word (set_word),
      .rsp_chan (rsp_chan)
   );

   // a new breakdown only loads while the last word of the old one leaves
   assert property (@(posedge clock) disable iff (reset)
      (set_valid && set_ready && rsp_chan.valid) |-> (rsp_chan.ready && rsp_chan.last_piece))
      else $error("breakdown loaded over pending words");

   // words of one amount come out in falling value order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_piece) |=>
      (rsp_chan.valid && (rsp_chan.piece_value < $past(rsp_chan.piece_value))))
      else $error("denomination order broken");

   // nothing is shown right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_chan.valid)
      else $error("word shown after reset");

endmodule

// ===== test/tb_greedy_change_maker_top.sv =====
`timescale 1ns / 1ps

module tb_greedy_change_maker_top;
   import gcm_pkg::*;

   localparam int AMT_W         = AMOUNT_BITS_DEFAULT;
   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CALM_ITEMS    = 30;
   localparam int SEGMENT_ITEMS = 25;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_GAP       = 18;
   localparam int NUM_DENOMS    = 10;
   localparam int DIRECTED_ROWS = 26;

   // us denominations in cents, largest first
   localparam int unsigned USD_CENTS [NUM_DENOMS] = '{
      10000, 5000, 2000, 1000, 500, 100, 25, 10, 5, 1
   };

   // gap modes for the sender
   typedef enum int {GAPS_NONE, GAPS_SPARSE, GAPS_DENSE} gap_mode_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
   } piece_word_type;

   // one directed amount; typed rows carry their single word (or none) by hand
   typedef struct packed {
      logic [AMT_W-1:0]      amount;
      logic                  typed;
      logic                  has_piece;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
   } amount_row_type;

   localparam amount_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{20'd0,       1'b1, 1'b0, 14'd0,     7'd0},
      '{20'd1,       1'b1, 1'b1, 14'd1,     7'd1},
      '{20'd4,       1'b1, 1'b1, 14'd1,     7'd4},
      '{20'd5,       1'b1, 1'b1, 14'd5,     7'd1},
      '{20'd10,      1'b1, 1'b1, 14'd10,    7'd1},
      '{20'd25,      1'b1, 1'b1, 14'd25,    7'd1},
      '{20'd100,     1'b1, 1'b1, 14'd100,   7'd1},
      '{20'd500,     1'b1, 1'b1, 14'd500,   7'd1},
      '{20'd1000,    1'b1, 1'b1, 14'd1000,  7'd1},
      '{20'd2000,    1'b1, 1'b1, 14'd2000,  7'd1},
      '{20'd5000,    1'b1, 1'b1, 14'd5000,  7'd1},
      '{20'd10000,   1'b1, 1'b1, 14'd10000, 7'd1},
      '{20'd1040000, 1'b1, 1'b1, 14'd10000, 7'd104},
      '{20'd1048575, 1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd0,       1'b1, 1'b0, 14'd0,     7'd0},
      '{20'd18893,   1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd99,      1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd524288,  1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd524287,  1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd9999,    1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd30,      1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd15,      1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd1048574, 1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd699050,  1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd349525,  1'b0, 1'b0, 14'd0,     7'd0},
      '{20'd0,       1'b1, 1'b0, 14'd0,     7'd0}
   };

   logic clock = 1'b0;
   logic reset;

   gcm_req_if #(.AMOUNT_BITS(AMT_W)) req_chan ();
   gcm_rsp_if                        rsp_chan ();

   greedy_change_maker_top #(
      .AMOUNT_BITS(AMT_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   piece_word_type expected_pieces [$];
   int             mismatch_count = 0;
   int             quiet_cycles   = 0;
   bit             calm_run       = 1'b0;
   gap_mode_type   gap_mode       = GAPS_NONE;

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // append one expected word at the tail of the queue
   function automatic void queue_piece(input piece_word_type word);
      expected_pieces.insert(expected_pieces.size(), word);
   endfunction

   // greedy split of one amount, queued largest denomination first
   function automatic void break_into_pieces(input logic [AMT_W-1:0] amount);
      logic [31:0]    rest;
      logic [31:0]    n;
      piece_word_type held;
      bit             have_held;
      rest      = 32'(amount);
      have_held = 1'b0;
      held      = '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
         n    = rest / USD_CENTS[i];
         rest = rest - n * USD_CENTS[i];
         if (n != 0) begin
            if (have_held) begin
               queue_piece(held);
            end
            held.value = VALUE_BITS'(USD_CENTS[i]);
            held.count = COUNT_BITS'(n);
            held.last  = 1'b0;
            have_held  = 1'b1;
         end
      end
      // final nonzero denomination carries the last flag
      if (have_held) begin
         held.last = 1'b1;
         queue_piece(held);
      end
   endfunction

   // random amount, mixing full range, small values and denomination edges
   function automatic logic [AMT_W-1:0] pick_amount();
      logic [31:0] sum;
      int          idx;
      sum = 0;
      case ($urandom_range(0, 5))
         0: sum = $urandom_range(0, (1 << AMT_W) - 1);
         1: sum = $urandom_range(0, 199);
         2: sum = $urandom_range(0, 19999);
         3: begin
            idx = $urandom_range(0, NUM_DENOMS - 1);
            sum = USD_CENTS[idx] * $urandom_range(1, 9);
         end
         4: begin
            for (int i = 0; i < NUM_DENOMS; i++) begin
               if ($urandom_range(0, 1) == 1) begin
                  sum = sum + USD_CENTS[i] * $urandom_range(1, 4);
               end
            end
         end
         default: begin
            idx = $urandom_range(0, NUM_DENOMS - 1);
            sum = USD_CENTS[idx] + $urandom_range(0, 2) - 1;
         end
      endcase
      if (sum >= (1 << AMT_W)) begin
         sum = (1 << AMT_W) - 1;
      end
      return AMT_W'(sum);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // offer one amount, queue its expected words, then maybe idle
   task automatic send_amount(input logic [AMT_W-1:0] amount, input bit typed,
                              input bit has_piece, input logic [VALUE_BITS-1:0] value,
                              input logic [COUNT_BITS-1:0] count);
      piece_word_type word;
      bit             take_gap;
      req_chan.valid        <= 1'b1;
      req_chan.amount_cents <= amount;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (typed) begin
         if (has_piece) begin
            word.value = value;
            word.count = count;
            word.last  = 1'b1;
            queue_piece(word);
         end
      end else begin
         break_into_pieces(amount);
      end
      @(negedge clock);
      case (gap_mode)
         GAPS_SPARSE: take_gap = ($urandom_range(0, 5) == 0);
         GAPS_DENSE:  take_gap = ($urandom_range(0, 1) == 0);
         default:     take_gap = 1'b0;
      endcase
      if (take_gap && !calm_run) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
      end
   endtask

   // hold off the sender until every expected word is back
   task automatic drain_pieces();
      req_chan.valid <= 1'b0;
      while (expected_pieces.size() != 0) @(negedge clock);
   endtask

   // receiver ready with stall bursts and long open stretches
   initial begin : rsp_ready_driver
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!calm_run && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24)) @(negedge clock);
      end
   end

   // word checker and watchdog
   always @(posedge clock) begin : rsp_checker
      piece_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_pieces.size() == 0) begin
            report_mismatch("unexpected word value", rsp_chan.piece_value, 0);
         end else begin
            want = expected_pieces.pop_front();
            if (rsp_chan.piece_value !== want.value) begin
               report_mismatch("piece_value", rsp_chan.piece_value, want.value);
            end
            if (rsp_chan.piece_count !== want.count) begin
               report_mismatch("piece_count", rsp_chan.piece_count, want.count);
            end
            if (rsp_chan.last_piece !== want.last) begin
               report_mismatch("last_piece", rsp_chan.last_piece, want.last);
            end
         end
      end
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, no word moved for %0d cycles, %0d words outstanding",
                  $time, STALL_LIMIT, expected_pieces.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin : amount_stimulus
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.amount_cents = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed amounts with gaps on both sides
      gap_mode = GAPS_SPARSE;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_amount(DIRECTED[r].amount, DIRECTED[r].typed, DIRECTED[r].has_piece,
                     DIRECTED[r].value, DIRECTED[r].count);
      end
      drain_pieces();

      // random amounts in segments of varying sender gaps, quiet at the tail
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % SEGMENT_ITEMS == 0) begin
            gap_mode = gap_mode_type'($urandom_range(0, 2));
         end
         if (i == RANDOM_ITEMS - CALM_ITEMS) begin
            calm_run = 1'b1;
            gap_mode = GAPS_NONE;
         end
         if (!calm_run && $urandom_range(0, 60) == 0) begin
            drain_pieces();
         end
         send_amount(pick_amount(), 1'b0, 1'b0, '0, '0);
      end
      req_chan.valid <= 1'b0;

      // let the last words drain, then settle to catch strays
      while (expected_pieces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
